FILE: design/smpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpn_pkg: shared types and constants of the stereo mix peak normaliser
// Beat formats, sequencer states, fixed-point widths and small helpers.
// ----------------------------------------------------------------------------
package smpn_pkg;

   localparam int SAMPLE_W   = 16;  // Q2.14 sample
   localparam int SUM_W      = 21;  // signed mix sum
   localparam int MAG_W      = 20;  // magnitude of a sum
   localparam int GAIN_W     = 17;  // Q1.16 gain
   localparam int PROD_W     = MAG_W + GAIN_W;
   localparam int DIVIDEND_W = 31;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int STEP_W     = 5;
   localparam int FRAMES_W   = 11;
   localparam int INDEX_W    = 10;
   localparam int WORD_W     = 2 * SUM_W;

   localparam logic [GAIN_W-1:0]     UNITY_GAIN   = 17'd65536;
   localparam logic [MAG_W-1:0]      UNITY_SAMPLE = 20'd16384;
   localparam logic [MAG_W-1:0]      SUM_LIMIT    = 20'd524288;
   localparam logic [DIVIDEND_W-1:0] GAIN_NUM     = 31'h4000_0000;
   localparam logic [PROD_W:0]       ROUND_HALF   = 38'd32768;

   typedef enum logic [1:0] {
      REQ_ACCUMULATE = 2'd0,
      REQ_FINISH     = 2'd1,
      REQ_READ       = 2'd2,
      REQ_NONE       = 2'd3
   } req_code_type;

   typedef enum logic {
      KIND_REPORT = 1'b0,
      KIND_FRAME  = 1'b1
   } rsp_kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_RD_ISSUE,
      ST_MUL_L,
      ST_MUL_R,
      ST_MUL_FIN,
      ST_WALK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]                 req_type;
      logic [INDEX_W-1:0]         frame_index;
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
      logic [FRAMES_W-1:0]        mix_frames;
   } req_beat_type;

   typedef struct packed {
      logic                       result_kind;
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic [MAG_W-1:0]           peak_level;
      logic [GAIN_W-1:0]          gain_out;
      logic [FRAMES_W-1:0]        frames_ready;
   } rsp_beat_type;

   // divider handshake towards the sequencer
   typedef struct packed {
      logic              done;
      logic              busy;
      logic [GAIN_W-1:0] quotient;
   } div_status_type;

   function automatic logic [MAG_W-1:0] sum_mag(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0] n;
      n = v[SUM_W-1] ? (~v + 1'b1) : v;
      return n[MAG_W-1:0];
   endfunction

   // saturating add of a sample into a sum, clamp to +/- SUM_LIMIT
   function automatic logic [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                input logic signed [SAMPLE_W-1:0] b);
      logic signed [SUM_W:0] s;
      s = {a[SUM_W-1], a} + {{(SUM_W+1-SAMPLE_W){b[SAMPLE_W-1]}}, b};
      if (s > $signed({2'b00, SUM_LIMIT})) begin
         s = $signed({2'b00, SUM_LIMIT});
      end else if (s < -$signed({2'b00, SUM_LIMIT})) begin
         s = -$signed({2'b00, SUM_LIMIT});
      end
      return s[SUM_W-1:0];
   endfunction

endpackage

FILE: design/stereo_mix_peak_normalizer.sv
`timescale 1ns / 1ps
// Accumulate: read, add and write back on the single store port; next beat waits.
// Read: store read, left then right scaling; next beat waits; one shared multiplier.
// Finish: one store read per frame for the peak walk, then the bit-serial gain
//   divider when the peak exceeds 1.0.
// Reset: synchronous; a clearing pass writes zero to all STORE_DEPTH store entries,
//   one per cycle, before the first request beat is taken. Gain resets to unity.
// ----------------------------------------------------------------------------
// stereo_mix_peak_normalizer: stereo frame mixer with peak normalisation
// Sums stereo source pairs into a frame store, finds the mix peak, derives a
// Q1.16 gain and returns scaled, cleared frames on demand.
// ----------------------------------------------------------------------------
module stereo_mix_peak_normalizer #(
   parameter int unsigned STORE_DEPTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  smpn_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output smpn_pkg::rsp_beat_type rsp_data
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);
   localparam int SW = smpn_pkg::SUM_W;

   // frame store: {left sum, right sum} per frame, single port, read first
   logic [smpn_pkg::WORD_W-1:0] store [STORE_DEPTH];

   // sequencer
   smpn_pkg::state_type state_ff, state_in;

   // control registers
   logic [AW-1:0]                  clr_addr_ff;
   logic [smpn_pkg::GAIN_W-1:0]    gain_ff;
   logic                           rsp_valid_ff;

   // payload registers
   smpn_pkg::req_beat_type         req_ff;
   logic                           in_range_ff;
   logic [smpn_pkg::FRAMES_W-1:0]  n_ff;
   logic [smpn_pkg::FRAMES_W-1:0]  walk_cnt_ff;
   logic                           rd_pend_ff;
   logic [smpn_pkg::MAG_W-1:0]     peak_ff;
   logic [smpn_pkg::WORD_W-1:0]    rd_word_ff;
   logic [smpn_pkg::PROD_W-1:0]    prod_ff;
   logic                           prod_neg_ff;
   logic [smpn_pkg::SAMPLE_W-1:0]  res_left_ff;
   logic [smpn_pkg::SAMPLE_W-1:0]  res_right_ff;
   smpn_pkg::rsp_beat_type         rsp_data_ff;

   // sequencer outputs
   logic                           mem_wr_en;
   logic                           mem_rd_en;
   logic [AW-1:0]                  mem_addr;
   logic [smpn_pkg::WORD_W-1:0]    mem_wr_data;
   logic                           div_start;
   logic                           rsp_load;
   logic                           walk_issue;

   smpn_pkg::div_status_type       div_status;

   // datapath
   logic                           accept;
   logic                           idx_in_range;
   logic [AW-1:0]                  req_addr;
   logic signed [SW-1:0]           cur_left;
   logic signed [SW-1:0]           cur_right;
   logic [smpn_pkg::MAG_W-1:0]     mag_left;
   logic [smpn_pkg::MAG_W-1:0]     mag_right;
   logic [smpn_pkg::MAG_W-1:0]     peak_next;
   logic                           walk_done;
   logic                           need_div;
   logic                           mul_right;
   logic [smpn_pkg::MAG_W-1:0]     mul_a;
   logic [smpn_pkg::PROD_W-1:0]    mul_prod;
   logic [smpn_pkg::PROD_W:0]      rnd_sum;
   logic [smpn_pkg::PROD_W-16:0]   rnd_mag;
   logic [smpn_pkg::SAMPLE_W-1:0]  clamp_mag;
   logic [smpn_pkg::SAMPLE_W-1:0]  scaled;
   smpn_pkg::rsp_beat_type         rsp_next;

   assign accept       = req_valid && !req_stall;
   assign idx_in_range = 32'(req_data.frame_index) < STORE_DEPTH;
   assign req_addr     = AW'(req_ff.frame_index);

   // out-of-range frames read as silence
   assign cur_left  = in_range_ff ? rd_word_ff[2*SW-1:SW] : '0;
   assign cur_right = in_range_ff ? rd_word_ff[SW-1:0]    : '0;
   assign mag_left  = smpn_pkg::sum_mag(rd_word_ff[2*SW-1:SW]);
   assign mag_right = smpn_pkg::sum_mag(rd_word_ff[SW-1:0]);

   always_comb begin
      peak_next = peak_ff;
      if (mag_left > peak_next) begin
         peak_next = mag_left;
      end
      if (mag_right > peak_next) begin
         peak_next = mag_right;
      end
   end

   assign walk_done = (walk_cnt_ff == n_ff) && !rd_pend_ff;
   assign need_div  = peak_ff > smpn_pkg::UNITY_SAMPLE;

   // ---- shared scaling multiplier: left channel, then right ----
   assign mul_right = (state_ff == smpn_pkg::ST_MUL_R);
   assign mul_a     = mul_right ? smpn_pkg::sum_mag(cur_right) : smpn_pkg::sum_mag(cur_left);
   assign mul_prod  = smpn_pkg::PROD_W'(mul_a) * smpn_pkg::PROD_W'(gain_ff);

   // round half up on the magnitude, clamp to 1.0, restore the sign
   assign rnd_sum   = {1'b0, prod_ff} + smpn_pkg::ROUND_HALF;
   assign rnd_mag   = rnd_sum[smpn_pkg::PROD_W:16];
   assign clamp_mag = (rnd_mag > (smpn_pkg::PROD_W-15)'(smpn_pkg::UNITY_SAMPLE))
                      ? smpn_pkg::SAMPLE_W'(smpn_pkg::UNITY_SAMPLE)
                      : rnd_mag[smpn_pkg::SAMPLE_W-1:0];
   assign scaled    = prod_neg_ff ? (~clamp_mag + 1'b1) : clamp_mag;

   // ---- gain divider ----
   smpn_gain_div u_gain_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (peak_ff),
      .status  (div_status)
   );

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smpn_pkg::ST_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = smpn_pkg::ST_IDLE;
            end
         end
         smpn_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_data.req_type)
                  smpn_pkg::REQ_ACCUMULATE: state_in = smpn_pkg::ST_ACC_RD;
                  smpn_pkg::REQ_FINISH:     state_in = smpn_pkg::ST_WALK;
                  smpn_pkg::REQ_READ:       state_in = smpn_pkg::ST_RD_ISSUE;
                  default:                  state_in = smpn_pkg::ST_IDLE;
               endcase
            end
         end
         smpn_pkg::ST_ACC_RD:   state_in = smpn_pkg::ST_ACC_WR;
         smpn_pkg::ST_ACC_WR:   state_in = smpn_pkg::ST_IDLE;
         smpn_pkg::ST_RD_ISSUE: state_in = smpn_pkg::ST_MUL_L;
         smpn_pkg::ST_MUL_L:    state_in = smpn_pkg::ST_MUL_R;
         smpn_pkg::ST_MUL_R:    state_in = smpn_pkg::ST_MUL_FIN;
         smpn_pkg::ST_MUL_FIN:  state_in = smpn_pkg::ST_RESP;
         smpn_pkg::ST_WALK: begin
            if (walk_done) begin
               state_in = smpn_pkg::ST_DIV_START;
            end
         end
         smpn_pkg::ST_DIV_START: begin
            state_in = need_div ? smpn_pkg::ST_DIV_WAIT : smpn_pkg::ST_RESP;
         end
         smpn_pkg::ST_DIV_WAIT: begin
            if (div_status.done) begin
               state_in = smpn_pkg::ST_RESP;
            end
         end
         smpn_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = smpn_pkg::ST_IDLE;
            end
         end
         default: state_in = smpn_pkg::ST_CLEAR;
      endcase
   end

   // ---- sequencer outputs ----
   always_comb begin
      req_stall   = 1'b1;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_addr    = req_addr;
      mem_wr_data = '0;
      div_start   = 1'b0;
      rsp_load    = 1'b0;
      walk_issue  = 1'b0;
      case (state_ff)
         smpn_pkg::ST_CLEAR: begin
            mem_wr_en = 1'b1;
            mem_addr  = clr_addr_ff;
         end
         smpn_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         smpn_pkg::ST_ACC_RD: begin
            mem_rd_en = 1'b1;
         end
         smpn_pkg::ST_ACC_WR: begin
            mem_wr_en   = in_range_ff;
            mem_wr_data = {smpn_pkg::sat_add(cur_left, req_ff.left_in),
                           smpn_pkg::sat_add(cur_right, req_ff.right_in)};
         end
         smpn_pkg::ST_RD_ISSUE: begin
            // read the frame and clear it in the same cycle (read first)
            mem_rd_en = 1'b1;
            mem_wr_en = in_range_ff;
         end
         smpn_pkg::ST_WALK: begin
            walk_issue = walk_cnt_ff != n_ff;
            mem_rd_en  = walk_issue;
            mem_addr   = AW'(walk_cnt_ff);
         end
         smpn_pkg::ST_DIV_START: begin
            div_start = need_div;
         end
         smpn_pkg::ST_RESP: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // ---- result beat ----
   always_comb begin
      rsp_next = '0;
      rsp_next.gain_out = gain_ff;
      if (req_ff.req_type == smpn_pkg::REQ_READ) begin
         rsp_next.result_kind = smpn_pkg::KIND_FRAME;
         rsp_next.left_out    = res_left_ff;
         rsp_next.right_out   = res_right_ff;
      end else begin
         rsp_next.result_kind  = smpn_pkg::KIND_REPORT;
         rsp_next.peak_level   = peak_ff;
         rsp_next.frames_ready = n_ff;
      end
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smpn_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         gain_ff      <= smpn_pkg::UNITY_GAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == smpn_pkg::ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (state_ff == smpn_pkg::ST_DIV_START && !need_div) begin
            gain_ff <= smpn_pkg::UNITY_GAIN;
         end else if (state_ff == smpn_pkg::ST_DIV_WAIT && div_status.done) begin
            gain_ff <= div_status.quotient;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff      <= req_data;
         in_range_ff <= idx_in_range;
         n_ff        <= (32'(req_data.mix_frames) > STORE_DEPTH)
                        ? smpn_pkg::FRAMES_W'(STORE_DEPTH) : req_data.mix_frames;
         walk_cnt_ff <= '0;
         rd_pend_ff  <= 1'b0;
         peak_ff     <= '0;
      end
      if (state_ff == smpn_pkg::ST_WALK) begin
         rd_pend_ff <= walk_issue;
         if (walk_issue) begin
            walk_cnt_ff <= walk_cnt_ff + 1'b1;
         end
         if (rd_pend_ff) begin
            peak_ff <= peak_next;
         end
      end
      if (state_ff == smpn_pkg::ST_MUL_L || state_ff == smpn_pkg::ST_MUL_R) begin
         prod_ff     <= mul_prod;
         prod_neg_ff <= mul_right ? cur_right[SW-1] : cur_left[SW-1];
      end
      if (state_ff == smpn_pkg::ST_MUL_R) begin
         res_left_ff <= scaled;
      end
      if (state_ff == smpn_pkg::ST_MUL_FIN) begin
         res_right_ff <= scaled;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   // ---- frame store ----
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         store[mem_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_word_ff <= store[mem_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_gain_bounded : assert property (@(posedge clock) disable iff (reset)
      gain_ff <= smpn_pkg::UNITY_GAIN)
      else $error("gain above unity");

   a_div_done_in_wait : assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == smpn_pkg::ST_DIV_WAIT)
      else $error("divider finished outside its wait state");

   a_store_write_state : assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == smpn_pkg::ST_CLEAR || state_ff == smpn_pkg::ST_ACC_WR
                     || state_ff == smpn_pkg::ST_RD_ISSUE))
      else $error("store written from an unexpected state");

   a_clear_quiet : assert property (@(posedge clock) disable iff (reset)
      state_ff == smpn_pkg::ST_CLEAR |-> !rsp_valid_ff && req_stall)
      else $error("activity during clearing pass");

   a_resp_handover : assert property (@(posedge clock) disable iff (reset)
      (state_ff == smpn_pkg::ST_RESP && !rsp_valid_ff)
         |=> (state_ff == smpn_pkg::ST_IDLE && rsp_valid_ff))
      else $error("result not handed to output register");
`endif

endmodule

FILE: design/smpn_gain_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpn_gain_div: restoring divider for the normalisation gain
// Computes round(2^30 / peak), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smpn_gain_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [smpn_pkg::MAG_W-1:0]   divisor,
   output smpn_pkg::div_status_type     status
);

   logic [smpn_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [smpn_pkg::MAG_W-1:0]      rem_ff, rem_in;
   logic [smpn_pkg::MAG_W-1:0]      dsr_ff, dsr_in;
   logic [smpn_pkg::STEP_W-1:0]     cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   logic [smpn_pkg::MAG_W:0] rem_sh;
   logic [smpn_pkg::MAG_W:0] rem_sub;
   logic                     take;

   assign rem_sh  = {rem_ff, quo_ff[smpn_pkg::DIVIDEND_W-1]};
   assign take    = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // dividend carries the half-divisor for rounding
         quo_in  = smpn_pkg::GAIN_NUM
                   + smpn_pkg::DIVIDEND_W'(divisor >> 1);
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[smpn_pkg::DIVIDEND_W-2:0], take};
         rem_in = take ? rem_sub[smpn_pkg::MAG_W-1:0] : rem_sh[smpn_pkg::MAG_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == smpn_pkg::STEP_W'(smpn_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign status.done     = done_ff;
   assign status.busy     = busy_ff;
   assign status.quotient = quo_ff[smpn_pkg::GAIN_W-1:0];

endmodule
